[hw/rtl/kvlt_pkg.sv]
// Shared constants, types and character classes for the key/value line tokeniser.
package kvlt_pkg;

  // Longest buffer that is parsed; later bytes halt the parse until the last byte.
  localparam int unsigned BUFFER_BYTES = 65536;
  // Position counter saturates at BUFFER_BYTES, so it must hold that value.
  localparam int unsigned POS_W = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned MODE_W = 3;

  localparam logic [MODE_W-1:0] MODE_LINE_START  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_COMMENT     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_KEY         = 3'd2;
  localparam logic [MODE_W-1:0] MODE_VALUE_START = 3'd3;
  localparam logic [MODE_W-1:0] MODE_VALUE       = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLOSE_QUOTE = 3'd5;
  localparam logic [MODE_W-1:0] MODE_HALTED      = 3'd6;

  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_TILDE   = 8'd126;
  localparam logic [7:0] CH_HASH    = 8'd35;
  localparam logic [7:0] CH_EQUALS  = 8'd61;
  localparam logic [7:0] CH_UNDER   = 8'd95;
  localparam logic [7:0] CH_QUOTE   = 8'd34;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_Z = 8'd90;
  localparam logic [7:0] CH_LOWER_A = 8'd97;
  localparam logic [7:0] CH_LOWER_Z = 8'd122;

  typedef struct packed {
    logic       last_byte;
    logic [7:0] text_byte;
  } kvlt_byte_t;

  typedef struct packed {
    logic [FIELD_W-1:0] value_length;
    logic [FIELD_W-1:0] value_offset;
    logic [FIELD_W-1:0] key_length;
    logic [FIELD_W-1:0] key_offset;
  } kvlt_result_t;

  function automatic logic is_key_char(input logic [7:0] c);
    return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
           (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c == CH_UNDER);
  endfunction

  function automatic logic is_printable(input logic [7:0] c);
    return (c >= CH_SPACE) && (c <= CH_TILDE);
  endfunction

endpackage

[hw/rtl/key_value_line_tokenizer.sv]
// Top level of the key/value line tokeniser: input register, parser, result register.
//
//  Channel | Direction | Transfer carries
//  in_     | slave     | tdata[7:0] text_byte, tlast last_byte
//  out_    | master    | tdata key_offset, key_length, value_offset, value_length
//
// One byte is taken per cycle when the result side keeps up; each byte lands in
// the input register, and the edge that advances it applies its parse-state
// update and (if it closes a good line) loads the result register, raising
// out_tvalid; a result stall can keep the byte waiting in the input register.
// The throughput is set by the single parse-state register, updated once per byte.
// rst_n is synchronous and active low; it clears the parse state and both valid flags.
// A stalled result holds the parser, which in turn holds the input register;
// in_tready drops only while a held byte cannot advance.
module key_value_line_tokenizer
  import kvlt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // [15:0] key_offset, [31:16] key_length,
                                  // [47:32] value_offset, [63:48] value_length
);

  kvlt_byte_t   in_byte;
  kvlt_byte_t   hold_byte;
  logic         hold_valid;
  logic         advance;
  logic         emit;
  kvlt_result_t result;
  kvlt_result_t out_data;

  assign in_byte.text_byte = in_tdata;
  assign in_byte.last_byte = in_tlast;

  // Advance the held byte whenever the result register is free or draining.
  assign advance = hold_valid && (!out_tvalid || out_tready);

  kvlt_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_byte    (in_byte),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  kvlt_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .cur     (hold_byte),
    .emit    (emit),
    .result  (result)
  );

  // Capture a result only on the newline byte that closes a good line.
  kvlt_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && emit),
    .load_data  (result),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_data   (out_data)
  );

  assign out_tdata = out_data;

endmodule

[hw/rtl/kvlt_in_reg.sv]
// Input register stage of the key/value line tokeniser.
module kvlt_in_reg
  import kvlt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  kvlt_byte_t in_byte,
  input  logic       advance,   // parser consumes the held byte this cycle
  output logic       hold_valid,
  output kvlt_byte_t hold_byte
);

  logic       valid_r, valid_nxt;
  kvlt_byte_t byte_r;
  logic       load;

  assign in_tready = !valid_r || advance;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_byte;
    end
  end

  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

  a_advance_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    advance |-> valid_r) else $error("advance without a held byte");

endmodule

[hw/rtl/kvlt_parser.sv]
// Line parse state and per-byte next-state logic of the key/value line tokeniser.
module kvlt_parser
  import kvlt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         advance,
  input  kvlt_byte_t   cur,
  output logic         emit,
  output kvlt_result_t result
);

  logic [MODE_W-1:0]  mode_r, mode_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [FIELD_W-1:0] key_begin_r, key_begin_nxt;
  logic [FIELD_W-1:0] key_count_r, key_count_nxt;
  logic [FIELD_W-1:0] value_begin_r, value_begin_nxt;
  logic [FIELD_W-1:0] value_count_r, value_count_nxt;
  logic [7:0]         c;

  assign c = cur.text_byte;

  always_comb begin
    mode_nxt        = mode_r;
    pos_nxt         = pos_r;
    key_begin_nxt   = key_begin_r;
    key_count_nxt   = key_count_r;
    value_begin_nxt = value_begin_r;
    value_count_nxt = value_count_r;
    emit            = 1'b0;

    if (pos_r >= POS_W'(BUFFER_BYTES)) begin
      mode_nxt = MODE_HALTED;
    end else begin
      pos_nxt = pos_r + POS_W'(1);
      unique case (mode_r)
        MODE_LINE_START: begin
          if (is_key_char(c)) begin
            key_begin_nxt = FIELD_W'(pos_r);
            key_count_nxt = FIELD_W'(1);
            mode_nxt      = MODE_KEY;
          end else if (c == CH_HASH) begin
            mode_nxt = MODE_COMMENT;
          end
        end
        MODE_COMMENT: begin
          if (c == CH_NEWLINE) begin
            mode_nxt = MODE_LINE_START;
          end
        end
        MODE_KEY: begin
          if (is_key_char(c)) begin
            key_count_nxt = key_count_r + FIELD_W'(1);
          end else if (c == CH_EQUALS) begin
            mode_nxt = MODE_VALUE_START;
          end else begin
            mode_nxt = MODE_LINE_START;
          end
        end
        MODE_VALUE_START: begin
          if (c == CH_QUOTE) begin
            mode_nxt = mode_r;
          end else if (is_printable(c)) begin
            value_begin_nxt = FIELD_W'(pos_r);
            value_count_nxt = FIELD_W'(1);
            mode_nxt        = MODE_VALUE;
          end else begin
            mode_nxt = MODE_HALTED;
          end
        end
        MODE_VALUE: begin
          if (c == CH_QUOTE) begin
            mode_nxt = MODE_CLOSE_QUOTE;
          end else if (c == CH_NEWLINE) begin
            emit = 1'b1;
          end else if (is_printable(c)) begin
            value_count_nxt = value_count_r + FIELD_W'(1);
          end else begin
            mode_nxt = MODE_HALTED;
          end
        end
        MODE_CLOSE_QUOTE: begin
          if (c == CH_NEWLINE) begin
            emit = 1'b1;
          end else begin
            mode_nxt = MODE_HALTED;
          end
        end
        default: begin
          mode_nxt = MODE_HALTED;
        end
      endcase
    end

    if (emit) begin
      value_count_nxt = '0;
      mode_nxt        = MODE_LINE_START;
    end

    // End of buffer: back to reset state for the next one.
    if (cur.last_byte) begin
      mode_nxt        = MODE_LINE_START;
      pos_nxt         = '0;
      key_begin_nxt   = '0;
      key_count_nxt   = '0;
      value_begin_nxt = '0;
      value_count_nxt = '0;
    end
  end

  assign result.key_offset   = key_begin_r;
  assign result.key_length   = key_count_r;
  assign result.value_offset = value_begin_r;
  assign result.value_length = value_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_LINE_START;
      pos_r         <= '0;
      key_begin_r   <= '0;
      key_count_r   <= '0;
      value_begin_r <= '0;
      value_count_r <= '0;
    end else if (advance) begin
      mode_r        <= mode_nxt;
      pos_r         <= pos_nxt;
      key_begin_r   <= key_begin_nxt;
      key_count_r   <= key_count_nxt;
      value_begin_r <= value_begin_nxt;
      value_count_r <= value_count_nxt;
    end
  end

  a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(BUFFER_BYTES)) else $error("byte position past saturation");

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && cur.last_byte) |=> (pos_r == '0 && mode_r == MODE_LINE_START))
    else $error("parse state not cleared after last byte");

  a_emit_has_value: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && emit) |-> (key_count_r != '0 &&
      (mode_r == MODE_VALUE || mode_r == MODE_CLOSE_QUOTE)))
    else $error("result emitted outside a value");

endmodule

[hw/rtl/kvlt_out_reg.sv]
// Result register of the key/value line tokeniser.
module kvlt_out_reg
  import kvlt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  kvlt_result_t load_data,
  output logic         out_tvalid,
  input  logic         out_tready,
  output kvlt_result_t out_data
);

  logic         valid_r, valid_nxt;
  kvlt_result_t data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_tvalid = valid_r;
  assign out_data   = data_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!valid_r || out_tready)) else $error("pending result overwritten");

endmodule

[bench/tb_top.sv]
// Self-checking stream testbench for the key/value line tokeniser.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kvlt_pkg::*;

  // Worst case is far below this: under five thousand bytes, each of which
  // may sit behind a result stall, plus one long hold-off.
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned PHASE_BYTES  = 300;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] text_byte
  logic        in_tlast;   // last_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // [15:0] key_offset, [31:16] key_length,
                           // [47:32] value_offset, [63:48] value_length

  // Handshake pacing, changed per phase by the test tasks.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_off_left = 0;

  int unsigned cycle_count = 0;
  int unsigned error_count = 0;

  // Bytes of the buffer being assembled, sent as one tlast-terminated run.
  logic [7:0] text_q[$];

  // Line records still owed by the block, oldest first.
  kvlt_result_t line_records_due[$];

  // Parser state as the tokeniser should hold it.
  logic [MODE_W-1:0]  tok_mode;
  logic [POS_W-1:0]   tok_pos;
  logic [FIELD_W-1:0] tok_key_begin;
  logic [FIELD_W-1:0] tok_key_count;
  logic [FIELD_W-1:0] tok_val_begin;
  logic [FIELD_W-1:0] tok_val_count;

  key_value_line_tokenizer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Guard against a hang: give up once the cycle budget is spent.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** key_value_line_tokenizer: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Character classes and line state
  // ---------------------------------------------------------------------------

  function automatic bit key_letter(input logic [7:0] c);
    return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
           (c >= CH_LOWER_A && c <= CH_LOWER_Z) || c == CH_UNDER;
  endfunction

  function automatic bit printable_char(input logic [7:0] c);
    return c >= CH_SPACE && c <= CH_TILDE;
  endfunction

  function automatic void clear_line_state();
    tok_mode      = MODE_LINE_START;
    tok_pos       = '0;
    tok_key_begin = '0;
    tok_key_count = '0;
    tok_val_begin = '0;
    tok_val_count = '0;
  endfunction

  // Advance the parser by one accepted byte; queue a line record when the
  // byte closes a good line. The last byte of a buffer is parsed first and
  // only then clears everything.
  function automatic void tokenise_byte(input logic [7:0] c, input logic last);
    bit           close_line;
    kvlt_result_t rec;
    close_line = 1'b0;
    if (tok_pos >= BUFFER_BYTES) begin
      // Past the end of the buffer window: stop parsing until the last byte.
      tok_mode = MODE_HALTED;
    end else begin
      case (tok_mode)
        MODE_LINE_START: begin
          if (key_letter(c)) begin
            tok_key_begin = tok_pos[FIELD_W-1:0];
            tok_key_count = FIELD_W'(1);
            tok_mode      = MODE_KEY;
          end else if (c == CH_HASH) begin
            tok_mode = MODE_COMMENT;
          end
        end
        MODE_COMMENT: begin
          if (c == CH_NEWLINE) tok_mode = MODE_LINE_START;
        end
        MODE_KEY: begin
          if (key_letter(c)) tok_key_count = tok_key_count + 1'b1;
          else if (c == CH_EQUALS) tok_mode = MODE_VALUE_START;
          else tok_mode = MODE_LINE_START;
        end
        MODE_VALUE_START: begin
          // Leading quotes are skipped; anything unprintable halts.
          if (c == CH_QUOTE) begin
            tok_mode = MODE_VALUE_START;
          end else if (printable_char(c)) begin
            tok_val_begin = tok_pos[FIELD_W-1:0];
            tok_val_count = FIELD_W'(1);
            tok_mode      = MODE_VALUE;
          end else begin
            tok_mode = MODE_HALTED;
          end
        end
        MODE_VALUE: begin
          if (c == CH_QUOTE) tok_mode = MODE_CLOSE_QUOTE;
          else if (c == CH_NEWLINE) close_line = 1'b1;
          else if (printable_char(c)) tok_val_count = tok_val_count + 1'b1;
          else tok_mode = MODE_HALTED;
        end
        MODE_CLOSE_QUOTE: begin
          if (c == CH_NEWLINE) close_line = 1'b1;
          else tok_mode = MODE_HALTED;
        end
        default: tok_mode = MODE_HALTED;
      endcase
      tok_pos = tok_pos + 1'b1;
    end

    if (close_line) begin
      rec.key_offset   = tok_key_begin;
      rec.key_length   = tok_key_count;
      rec.value_offset = tok_val_begin;
      rec.value_length = tok_val_count;
      line_records_due.push_back(rec);
      tok_val_count = '0;
      tok_mode      = MODE_LINE_START;
    end

    if (last) clear_line_state();
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one byte, with random idle cycles first, and hold it until the
  // transfer happens. Inputs move on the falling edge only.
  task automatic send_byte(input logic [7:0] c, input logic last);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = c;
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    tokenise_byte(c, last);
  endtask

  // Send the assembled buffer with tlast on its final byte, then drop tvalid.
  task automatic send_buffer();
    int unsigned n;
    n = text_q.size();
    for (int unsigned i = 0; i < n; i++) send_byte(text_q[i], i == n - 1);
    text_q.delete();
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_records_drained();
    while (line_records_due.size() != 0) @(posedge clk);
  endtask

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] rand_key_letter();
    int unsigned idx;
    idx = $urandom_range(0, 52);
    if (idx < 26) return 8'(CH_UPPER_A + idx);
    if (idx < 52) return 8'(CH_LOWER_A + idx - 26);
    return CH_UNDER;
  endfunction

  // Printable, but never a quote, so the value runs on.
  function automatic logic [7:0] rand_value_char();
    logic [7:0] c;
    do c = 8'($urandom_range(CH_SPACE, CH_TILDE)); while (c == CH_QUOTE);
    return c;
  endfunction

  function automatic void put_key(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) text_q.push_back(rand_key_letter());
  endfunction

  function automatic void put_value(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) text_q.push_back(rand_value_char());
  endfunction

  // KEY=VALUE line, optionally quoted, closed by a newline.
  function automatic void put_good_line(input int unsigned key_len,
                                        input int unsigned val_len);
    int unsigned quotes;
    quotes = $urandom_range(0, 2);
    put_key(key_len);
    text_q.push_back(CH_EQUALS);
    repeat (quotes) text_q.push_back(CH_QUOTE);
    put_value(val_len);
    if ($urandom_range(0, 1)) text_q.push_back(CH_QUOTE);
    text_q.push_back(CH_NEWLINE);
  endfunction

  // Lines that stop the parse for the rest of the buffer.
  function automatic void put_halting_line();
    logic [7:0] c;
    put_key($urandom_range(1, 5));
    text_q.push_back(CH_EQUALS);
    case ($urandom_range(0, 3))
      0: text_q.push_back(CH_NEWLINE);                 // empty value
      1: begin                                         // unprintable in value
        put_value($urandom_range(1, 6));
        do c = 8'($urandom_range(0, 255)); while (printable_char(c) || c == CH_NEWLINE);
        text_q.push_back(c);
      end
      2: begin                                         // junk after closing quote
        put_value($urandom_range(1, 6));
        text_q.push_back(CH_QUOTE);
        do c = 8'($urandom_range(0, 255)); while (c == CH_NEWLINE);
        text_q.push_back(c);
      end
      default: begin                                   // quote then newline
        text_q.push_back(CH_QUOTE);
        text_q.push_back(CH_NEWLINE);
      end
    endcase
    put_value($urandom_range(0, 4));
    text_q.push_back(CH_NEWLINE);
  endfunction

  // Mostly good lines with random content; comments, bad keys, noise and
  // the odd halting line for the rest.
  function automatic void put_random_line();
    int unsigned pick;
    logic [7:0]  c;
    pick = $urandom_range(0, 99);
    if (pick < 62) begin
      if ($urandom_range(0, 19) == 0)
        put_good_line($urandom_range(1, 24), $urandom_range(1, 60));
      else
        put_good_line($urandom_range(1, 6), $urandom_range(1, 12));
    end else if (pick < 72) begin
      text_q.push_back(CH_HASH);
      repeat ($urandom_range(0, 6)) begin
        do c = 8'($urandom_range(0, 255)); while (c == CH_NEWLINE);
        text_q.push_back(c);
      end
      text_q.push_back(CH_NEWLINE);
    end else if (pick < 88) begin
      // Key broken by a byte that is neither a key letter nor '='.
      put_key($urandom_range(1, 5));
      do c = 8'($urandom_range(0, 255)); while (key_letter(c) || c == CH_EQUALS);
      text_q.push_back(c);
      if ($urandom_range(0, 1)) text_q.push_back(CH_NEWLINE);
    end else if (pick < 94) begin
      put_halting_line();
    end else begin
      repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct     = 0;
    // Shortest good line; the record is due on the last byte itself.
    put_text("A=1\n");
    send_buffer();
    // Top byte value at line start, a comment hiding '=', quoted tilde value.
    text_q.push_back(8'hFF);
    put_text("#k=v\n_z=\"~\"\n");
    send_buffer();
    // '#' inside a key, then an empty value that halts the rest.
    text_q.push_back(8'h00);
    put_text("a#\nq=\nz=9\n");
    send_buffer();
    wait_records_drained();
  endtask

  // One longer buffer: a long key and a long value well into the buffer,
  // and a record on its final byte.
  task automatic test_long_buffer();
    send_idle_pct = 0;
    stall_pct     = 0;
    put_good_line(3, 5);
    put_good_line(30, 200);
    put_text("AB=CD\n");
    send_buffer();
    wait_records_drained();
  endtask

  task automatic test_random_phase(input int unsigned idle_pct,
                                   input int unsigned stall_in_pct);
    int unsigned sent;
    send_idle_pct = idle_pct;
    stall_pct     = stall_in_pct;
    sent          = 0;
    while (sent < PHASE_BYTES) begin
      repeat ($urandom_range(1, 8)) put_random_line();
      sent += text_q.size();
      send_buffer();
    end
    wait_records_drained();
  endtask

  // Hold the result side off while bytes keep coming so the pipeline backs
  // up into in_tready, then pause the sender until every record is out.
  task automatic test_back_pressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_off_left = 400;
    repeat (20) put_good_line($urandom_range(1, 3), $urandom_range(1, 4));
    send_buffer();
    wait_records_drained();
    repeat (10) put_good_line($urandom_range(1, 3), $urandom_range(1, 4));
    send_buffer();
    wait_records_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Ready pattern, changed on the falling edge; a long hold-off wins.
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_tready = 1'b0;
      hold_off_left--;
    end else begin
      out_tready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic compare_field(input string name, input logic [FIELD_W-1:0] want,
                               input logic [FIELD_W-1:0] got);
    if (got !== want) begin
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_records
    kvlt_result_t got;
    kvlt_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (line_records_due.size() == 0) begin
        $display("%0t unexpected record: expected none, actual %h", $time, got);
        error_count++;
      end else begin
        want = line_records_due.pop_front();
        compare_field("key_offset", want.key_offset, got.key_offset);
        compare_field("key_length", want.key_length, got.key_length);
        compare_field("value_offset", want.value_offset, got.value_offset);
        compare_field("value_length", want.value_length, got.value_length);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    clear_line_state();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_phase(0, 0);
    test_random_phase(87, 0);
    test_random_phase(0, 87);
    test_random_phase(9, 9);
    test_back_pressure();
    test_long_buffer();

    wait_records_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && line_records_due.size() == 0) begin
      $display("** key_value_line_tokenizer: PASSED **");
    end else begin
      $display("** key_value_line_tokenizer: FAILED **");
    end
    $finish;
  end

endmodule
